// ===== hw/rtl/vdi_pkg.sv =====
`default_nettype none

package vdi_pkg;

  localparam int MAX_VERTS_DEFAULT = 1024;
  localparam int WORD_W = 32;
  localparam int WORDS_PER_VERT = 8;
  localparam int VERT_W = WORD_W * WORDS_PER_VERT;
  localparam int INDEX_W = 10;

  typedef struct packed {
    logic              start_new;
    logic [WORD_W-1:0] pos_x;
    logic [WORD_W-1:0] pos_y;
    logic [WORD_W-1:0] pos_z;
    logic [WORD_W-1:0] tex_u;
    logic [WORD_W-1:0] tex_v;
    logic [WORD_W-1:0] norm_x;
    logic [WORD_W-1:0] norm_y;
    logic [WORD_W-1:0] norm_z;
  } in_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic               is_new;
    logic               table_full;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_RESULT
  } state_t;

  // status from the datapath to the sequencer
  typedef struct packed {
    logic in_fire;
    logic start_new;
    logic hit;
    logic out_free;
  } ctrl_stat_t;

  // commands from the sequencer to the datapath
  typedef struct packed {
    logic busy;
    logic rd_en;
    logic wr_en;
    logic res_load;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vdi_ram.sv =====
`default_nettype none

module vdi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vdi_ctrl.sv =====
`default_nettype none

module vdi_ctrl
  import vdi_pkg::*;
#(
  parameter int MAX_VERTS = MAX_VERTS_DEFAULT,
  localparam int AW = $clog2(MAX_VERTS),
  localparam int CW = $clog2(MAX_VERTS + 1)
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire ctrl_stat_t stat,
  output ctrl_cmd_t       cmd,
  output logic [AW-1:0]   rd_addr,
  output logic [AW-1:0]   wr_addr,
  output out_item_t       result
);

  localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_VERTS);

  state_t        state;
  state_t        state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] issue_ptr;
  logic [AW-1:0] cmp_ptr;
  logic          cmp_vld;
  logic          found;
  logic [AW-1:0] found_idx;

  logic hit_now;
  logic more;
  logic full;

  assign hit_now = cmp_vld && stat.hit;
  assign more    = issue_ptr < count;
  assign full    = count == COUNT_MAX;
  assign rd_addr = issue_ptr[AW-1:0];
  assign wr_addr = count[AW-1:0];

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (stat.in_fire) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (hit_now || (!more && !cmp_vld)) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd    = '0;
    result = '0;
    unique case (state)
      ST_IDLE: begin
      end
      ST_SCAN: begin
        cmd.busy  = 1'b1;
        cmd.rd_en = !hit_now && more;
      end
      ST_RESULT: begin
        cmd.busy     = 1'b1;
        cmd.res_load = stat.out_free;
        cmd.wr_en    = stat.out_free && !found && !full;
        priority if (found) begin
          result.vertex_index = INDEX_W'(found_idx);
        end else if (full) begin
          result.table_full = 1'b1;
        end else begin
          result.vertex_index = INDEX_W'(count);
          result.is_new       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      cmp_vld <= 1'b0;
      found   <= 1'b0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (stat.in_fire) begin
            if (stat.start_new) begin
              count <= '0;
            end
            issue_ptr <= '0;
            cmp_vld   <= 1'b0;
            found     <= 1'b0;
          end
        end
        ST_SCAN: begin
          priority if (hit_now) begin
            found     <= 1'b1;
            found_idx <= cmp_ptr;
            cmp_vld   <= 1'b0;
          end else if (more) begin
            cmp_vld   <= 1'b1;
            cmp_ptr   <= issue_ptr[AW-1:0];
            issue_ptr <= issue_ptr + 1'b1;
          end else begin
            cmp_vld <= 1'b0;
          end
        end
        ST_RESULT: begin
          if (cmd.wr_en) begin
            count <= count + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/vertex_dedup_indexer.sv =====
`default_nettype none

// Vertex deduplicator: each input transaction carries one vertex (eight raw 32-bit words,
// compared bit for bit) and returns one output transaction with the index of the
// matching stored vertex, or the next free index with is_new set, or table_full when
// a new vertex finds all MAX_VERTS entries in use (nothing is stored then and the
// index reads 0). start_new empties the store before its own vertex is handled. The
// store is a single RAM with one read and one write port, scanned one entry per cycle
// from index 0. A miss reads every entry stored since the last start before its result
// is formed; a hit stops the scan at the matching index. A result that cannot move
// into the output register waits in the sequencer until that register is free.
// The input stalls for the whole search and during reset; a finished result sits in
// an output register, so the next vertex is accepted while it waits. The store needs
// no clearing pass after reset: only entries below the fill count are ever read.
module vertex_dedup_indexer
  import vdi_pkg::*;
#(
  parameter int MAX_VERTS = MAX_VERTS_DEFAULT
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_item,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_item
);

  localparam int AW = $clog2(MAX_VERTS);

  logic [VERT_W-1:0] vtx;
  logic [VERT_W-1:0] rd_data;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  ctrl_stat_t        stat;
  ctrl_cmd_t         cmd;
  out_item_t         result;
  logic              in_fire;

  assign in_stall = rst || cmd.busy;
  assign in_fire  = in_valid && !in_stall;

  assign stat.in_fire   = in_fire;
  assign stat.start_new = in_item.start_new;
  assign stat.hit       = rd_data == vtx;
  assign stat.out_free  = !out_valid || !out_stall;

  // captured vertex words
  always_ff @(posedge clk) begin
    if (in_fire) begin
      vtx <= {in_item.pos_x, in_item.pos_y, in_item.pos_z, in_item.tex_u,
              in_item.tex_v, in_item.norm_x, in_item.norm_y, in_item.norm_z};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_item <= result;
    end
  end

  vdi_ctrl #(
    .MAX_VERTS(MAX_VERTS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .stat    (stat),
    .cmd     (cmd),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .result  (result)
  );

  vdi_ram #(
    .WIDTH(VERT_W),
    .DEPTH(MAX_VERTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wr_addr),
    .wr_data (vtx),
    .rd_en   (cmd.rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/vdi_checker.sv =====
`default_nettype none

module vdi_checker
  import vdi_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_item,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_item
);

  // a stalled transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_item))
    else $error("stalled transaction changed");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled result changed");

  // the search always takes the cycle after a transaction
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled during search");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_item.is_new && out_item.table_full))
    else $error("is_new and table_full both set");

  a_full_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.table_full |-> out_item.vertex_index == '0)
    else $error("full result carries an index");

endmodule

bind vertex_dedup_indexer vdi_checker u_vdi_checker (.*);

`default_nettype wire
